// ===== rtl/dfsr_pkg.sv =====
package dfsr_pkg;

	localparam int FRACTION_DIGITS = 6;

	localparam int RADICAND_W = 40;
	localparam int ROOT_W = 30;

	// The scaled radicand is held in twice the root width.
	localparam int SQ_W = 2 * ROOT_W;
	// The partial remainder carries room for two new bits and one carry.
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);

	// The magnitude of a non-negative radicand is split into two halves for scaling.
	localparam int MAG_W = RADICAND_W - 1;
	localparam int LO_W = 20;
	localparam int HI_W = MAG_W - LO_W;
	localparam int SCALE_W = 20;

	function automatic logic [63:0] scale_value();
		logic [63:0] s;
		s = 64'd1;
		for (int i = 0; i < FRACTION_DIGITS; i++) begin
			s = s * 64'd10;
		end
		return s;
	endfunction

	localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(scale_value());

	typedef struct packed {
		logic start;
		logic mul_lo;
		logic mul_hi;
		logic iter;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic negative;
	} status_t;

endpackage

// ===== rtl/decimal_fixed_square_root.sv =====
// Square root of a signed decimal fixed-point value in millionths.
// Input channel: in_valid / in_stall carry radicand (40-bit two's complement).
// A transaction is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry root (30 bits, millionths) and
// negative_error; a transaction completes when out_valid is high and out_stall low.
// root is floor(sqrt(radicand * 10^6)); for a negative radicand root is zero and
// negative_error is set.
// Sequence: a non-negative item goes through two scaling steps on a split 20-bit
// constant multiply, then 30 restoring iterations producing one root bit each,
// then the output load, which waits for a free output register. A negative
// item goes from the first scaling step straight to the output load.
// The block takes one item at a time; the next item is taken the cycle after
// the result is loaded.
// The finished result sits in an output register, so a new item is accepted
// while it waits. If out_stall stays high when the next result is ready, that
// result holds inside and in_stall stays high until the register frees.
// Reset (arst_n low) drops any item in flight and clears out_valid.
module decimal_fixed_square_root (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dfsr_pkg::RADICAND_W-1:0] radicand,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dfsr_pkg::ROOT_W-1:0]     root,
	output logic                            negative_error
);

	dfsr_pkg::cmd_t    cmd;
	dfsr_pkg::status_t status;

	// Sequence the scaling, iteration and output load.
	dfsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold the operand, scaled radicand, remainder, root and output register.
	dfsr_datapath u_datapath (
		.clk            (clk),
		.radicand       (radicand),
		.cmd            (cmd),
		.status         (status),
		.root           (root),
		.negative_error (negative_error)
	);

endmodule

// ===== rtl/dfsr_datapath.sv =====
module dfsr_datapath (
	input  logic                          clk,
	input  logic [dfsr_pkg::RADICAND_W-1:0] radicand,
	input  dfsr_pkg::cmd_t                cmd,
	output dfsr_pkg::status_t             status,
	output logic [dfsr_pkg::ROOT_W-1:0]   root,
	output logic                          negative_error
);

	logic [dfsr_pkg::MAG_W-1:0]   mag_q;
	logic                         neg_q;
	logic [dfsr_pkg::SQ_W-1:0]    scaled_q;
	logic [dfsr_pkg::REM_W-1:0]   rem_q;
	logic [dfsr_pkg::ROOT_W-1:0]  root_q;

	logic [dfsr_pkg::LO_W+dfsr_pkg::SCALE_W-1:0] lo_prod;
	logic [dfsr_pkg::HI_W+dfsr_pkg::SCALE_W-1:0] hi_prod;
	logic [dfsr_pkg::SQ_W-1:0]    hi_term;
	logic [dfsr_pkg::REM_W-1:0]   trial;
	logic [dfsr_pkg::REM_W-1:0]   divisor;
	logic                         fits;

	assign lo_prod = mag_q[dfsr_pkg::LO_W-1:0] * dfsr_pkg::SCALE;
	assign hi_prod = mag_q[dfsr_pkg::MAG_W-1:dfsr_pkg::LO_W] * dfsr_pkg::SCALE;
	assign hi_term = dfsr_pkg::SQ_W'({hi_prod, {dfsr_pkg::LO_W{1'b0}}});

	// Bring down the next two radicand bits and try the odd trial divisor.
	assign trial = {rem_q[dfsr_pkg::REM_W-3:0], scaled_q[dfsr_pkg::SQ_W-1 -: 2]};
	assign divisor = dfsr_pkg::REM_W'({root_q, 2'b01});
	assign fits = trial >= divisor;

	assign status.negative = neg_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mag_q <= radicand[dfsr_pkg::MAG_W-1:0];
			neg_q <= radicand[dfsr_pkg::RADICAND_W-1];
			rem_q <= '0;
			root_q <= '0;
		end
		if (cmd.mul_lo) begin
			scaled_q <= dfsr_pkg::SQ_W'(lo_prod);
		end else if (cmd.mul_hi) begin
			scaled_q <= scaled_q + hi_term;
		end else if (cmd.iter) begin
			scaled_q <= {scaled_q[dfsr_pkg::SQ_W-3:0], 2'b00};
			rem_q <= fits ? (trial - divisor) : trial;
			root_q <= {root_q[dfsr_pkg::ROOT_W-2:0], fits};
		end
		if (cmd.load_out) begin
			root <= neg_q ? '0 : root_q;
			negative_error <= neg_q;
		end
	end

endmodule

// ===== rtl/dfsr_ctrl.sv =====
module dfsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  dfsr_pkg::status_t status,
	output dfsr_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL_LO = 3'd1;
	localparam logic [2:0] S_MUL_HI = 3'd2;
	localparam logic [2:0] S_ITER   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	localparam logic [dfsr_pkg::CNT_W-1:0] LAST_ITER = dfsr_pkg::CNT_W'(dfsr_pkg::ROOT_W - 1);

	logic [2:0]                 state_q;
	logic [2:0]                 state_d;
	logic [dfsr_pkg::CNT_W-1:0] count_q;
	logic                       out_valid_q;
	logic                       slot_free;

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = S_MUL_LO;
				end
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				// Negative input has no root: go straight to the result.
				state_d = status.negative ? S_FINISH : S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d = S_ITER;
			end
			S_ITER: begin
				cmd.iter = 1'b1;
				if (count_q == LAST_ITER) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != S_ITER) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MUL_LO))
		else $error("accepted transaction did not start scaling");

	a_iter_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && count_q == LAST_ITER) |=> (state_q == S_FINISH))
		else $error("iteration count overran");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |-> (count_q <= LAST_ITER))
		else $error("iteration counter out of range");

endmodule

// ===== test/root_checker.sv =====
`timescale 1ns / 1ps

module root_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [dfsr_pkg::RADICAND_W-1:0] radicand,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [dfsr_pkg::ROOT_W-1:0]     root,
	input  logic                            negative_error,
	output int                              outstanding,
	output int                              results_seen,
	output int                              failures
);

	localparam logic [63:0] UNIT_SCALE = 64'(10 ** dfsr_pkg::FRACTION_DIGITS);

	typedef struct packed {
		logic [dfsr_pkg::ROOT_W-1:0] root;
		logic                        negative;
	} root_result_t;

	root_result_t pending_roots[$];

	// Build the root one bit at a time from the top, keeping a bit while its square fits.
	function automatic root_result_t expected_root(input logic [dfsr_pkg::RADICAND_W-1:0] value);
		root_result_t r;
		logic [63:0]  scaled;
		logic [63:0]  trial;
		r.root = '0;
		r.negative = value[dfsr_pkg::RADICAND_W-1];
		if (!r.negative) begin
			scaled = 64'(value[dfsr_pkg::RADICAND_W-2:0]) * UNIT_SCALE;
			for (int b = dfsr_pkg::ROOT_W - 1; b >= 0; b--) begin
				trial = 64'(r.root) | (64'd1 << b);
				if (trial * trial <= scaled) begin
					r.root = trial[dfsr_pkg::ROOT_W-1:0];
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : watch
		root_result_t want;
		int           errs;
		errs = 0;
		if (!arst_n) begin
			pending_roots.delete();
			outstanding <= 0;
			results_seen <= 0;
			failures <= 0;
		end else begin
			// Compare before queuing so a result never matches an item taken at the same edge.
			if (out_valid && !out_stall) begin
				if (pending_roots.size() == 0) begin
					$error("unexpected transaction: root %0d negative_error %0b",
						root, negative_error);
					errs++;
				end else begin
					want = pending_roots.pop_front();
					if (root !== want.root) begin
						$error("root: expected %0d, actual %0d", want.root, root);
						errs++;
					end
					if (negative_error !== want.negative) begin
						$error("negative_error: expected %0b, actual %0b",
							want.negative, negative_error);
						errs++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (in_valid && !in_stall) begin
				pending_roots.insert(pending_roots.size(), expected_root(radicand));
			end
			outstanding <= pending_roots.size();
			failures <= failures + errs;
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int ITEM_COUNT = 1900;
	// Items at the end of the run sent with no idling on either side.
	localparam int CALM_TAIL = 200;
	localparam int CYCLE_LIMIT = 1_000_000;
	// Long receiver hold-off, started once enough results have gone by.
	localparam int HOLD_AFTER = 40;
	localparam int HOLD_CYCLES = 400;
	// Settle time after the last result, longer than the block's latency.
	localparam int DRAIN_CYCLES = 40;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [dfsr_pkg::RADICAND_W-1:0] radicand = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [dfsr_pkg::ROOT_W-1:0]     root;
	logic                            negative_error;

	int outstanding;
	int results_seen;
	int failures;

	int tx_rate = 2;
	int rx_rate = 2;
	bit calm = 1'b0;
	int rx_hold = 0;
	int rx_burst = 0;
	bit hold_done = 1'b0;
	int cycles = 0;
	int sent = 0;
	int negatives = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	decimal_fixed_square_root dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.radicand       (radicand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.root           (root),
		.negative_error (negative_error)
	);

	root_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.radicand       (radicand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.root           (root),
		.negative_error (negative_error),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.failures       (failures)
	);

	// Offer one radicand, optionally after an idle burst, and hold it until the
	// transaction completes. Leaves in_valid high so back-to-back items need no toggle.
	task automatic send_radicand(input logic [dfsr_pkg::RADICAND_W-1:0] value);
		if (!calm && $urandom_range(0, 9) < tx_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		radicand <= value;
		do @(posedge clk); while (in_stall);
		sent++;
		if (value[dfsr_pkg::RADICAND_W-1]) begin
			negatives++;
		end
	endtask

	// Mix of shapes: negatives, full-range positives, small values, values that
	// sit right on a truncation boundary, and values just under the top.
	function automatic logic [dfsr_pkg::RADICAND_W-1:0] random_radicand();
		logic [63:0] bits;
		logic [63:0] edge_root;
		bits = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0, 1: begin
				return {1'b1, bits[dfsr_pkg::RADICAND_W-2:0]};
			end
			2, 3: begin
				return {1'b0, bits[dfsr_pkg::RADICAND_W-2:0]};
			end
			4, 5: begin
				return dfsr_pkg::RADICAND_W'(bits[23:0] >> $urandom_range(0, 23));
			end
			6, 7, 8: begin
				// Pick a root, then land on the last value below or first at its square.
				edge_root = 64'($urandom_range(0, 741_000_000));
				edge_root = edge_root * edge_root / 64'd1_000_000
					+ 64'($urandom_range(0, 1));
				return dfsr_pkg::RADICAND_W'(edge_root);
			end
			default: begin
				return {1'b0, {(dfsr_pkg::RADICAND_W-1){1'b1}}}
					- dfsr_pkg::RADICAND_W'(bits[15:0]);
			end
		endcase
	endfunction

	// Receiver: random stall bursts, one long hold-off to back the block up into
	// its input, and a clean stretch at the end.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			rx_hold <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else if (rx_burst > 0) begin
			rx_burst <= rx_burst - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) < rx_rate) begin
			rx_burst <= $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [dfsr_pkg::RADICAND_W-1:0] corners[$];
		// Zero, tiny values, exact squares, the two ends of each sign and
		// alternating bit patterns.
		corners = '{
			40'd0, 40'd1, 40'd2, 40'd3, 40'd4, 40'd100, 40'd250_000,
			40'd999_999, 40'd1_000_000, 40'd1_000_001, 40'd2_000_000, 40'd4_000_000,
			40'h55_5555_5555, 40'h2A_AAAA_AAAA, 40'h40_0000_0000,
			40'h7F_FFFF_FFFE, 40'h7F_FFFF_FFFF,
			40'hFF_FFFF_FFFF, 40'h80_0000_0000, 40'hFF_FFF0_BDC0,
			40'hAA_AAAA_AAAA, 40'hD5_5555_5555
		};

		// Hold reset, then release it at an edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[k]) begin
			send_radicand(corners[k]);
		end

		for (int n = 0; n < ITEM_COUNT; n++) begin
			// Redraw idle pressure every hundred items; a zero rate gives a clean stretch.
			if (n % 100 == 0) begin
				tx_rate = $urandom_range(0, 4);
				rx_rate <= $urandom_range(0, 4);
			end
			if (n == ITEM_COUNT - CALM_TAIL) begin
				calm <= 1'b1;
			end
			send_radicand(random_radicand());
		end
		in_valid <= 1'b0;

		// Drain every owed result, then give stray results a chance to show up.
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d radicands (%0d negative), checked %0d roots in %0d cycles",
			sent, negatives, results_seen, cycles);
		$display("included a %0d-cycle receiver hold-off with the input backed up",
			HOLD_CYCLES);
		if (failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
